[rtl/lpf_pkg.sv]
// Package for the line prefix filter: field widths, codes and character constants.
// Used by the channel interfaces, the prefix match unit and the top level.
package lpf_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned PLEN_W     = 4;
  localparam int unsigned MAXLEN_W   = 10;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned LINE_CNT_W = 11;

  localparam logic [DATA_W-1:0] WILDCARD = 8'h3F;
  localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;

  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_CHARS    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LENGTH   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE_LENGTH = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LIMIT   = 4'd3;

  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 10'd255;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd100;

  typedef enum logic [OPCODE_W-1:0] {
    OP_BYTE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_START   = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_NO_DATA  = 2'd1,
    ST_LINE_ERR = 2'd2,
    ST_LIMIT    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_START    = 2'd1,
    PH_LINE     = 2'd2,
    PH_AFTER_CR = 2'd3
  } phase_e;

  typedef struct packed {
    logic byte_miss;
    logic tail_miss;
  } match_t;

endpackage

[rtl/lpf_if.sv]
// Valid/ready channel interfaces of the line prefix filter: items, results, configuration.
// Depends on lpf_pkg for the field widths.
interface lpf_in_if;
  logic                        valid;
  logic                        ready;
  logic [lpf_pkg::OPCODE_W-1:0] opcode;
  logic [lpf_pkg::DATA_W-1:0]   data_byte;
  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface lpf_out_if;
  logic                        valid;
  logic                        ready;
  logic [lpf_pkg::STATUS_W-1:0] search_status;
  logic [lpf_pkg::INDEX_W-1:0]  message_index;
  modport source (output valid, output search_status, output message_index, input ready);
  modport sink   (input valid, input search_status, input message_index, output ready);
endinterface

interface lpf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lpf_pkg::CFG_IDX_W-1:0]  index;
  logic [lpf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/lpf_match.sv]
// Prefix compare of the line prefix filter: per-byte mismatch and end-of-line tail check.
// Depends on lpf_pkg for widths, the wildcard code and the match_t result struct.
module lpf_match #(
  parameter int unsigned PREFIX_BYTES = 8
) (
  input  logic [PREFIX_BYTES*lpf_pkg::DATA_W-1:0] prefix_i,
  input  logic [lpf_pkg::PLEN_W-1:0]              prefix_len_i,
  input  logic [lpf_pkg::LINE_CNT_W-1:0]          line_cnt_i,
  input  logic [lpf_pkg::DATA_W-1:0]              data_byte_i,
  output lpf_pkg::match_t                         match_o
);

  logic [lpf_pkg::PLEN_W-1:0] eff_len;

  assign eff_len = (prefix_len_i > lpf_pkg::PLEN_W'(PREFIX_BYTES)) ?
                   lpf_pkg::PLEN_W'(PREFIX_BYTES) : prefix_len_i;

  always_comb begin
    logic [lpf_pkg::DATA_W-1:0] pb;
    logic                       in_len;
    logic                       fixed;
    match_o = '0;
    for (int j = 0; j < PREFIX_BYTES; j++) begin
      pb     = prefix_i[j*lpf_pkg::DATA_W +: lpf_pkg::DATA_W];
      in_len = lpf_pkg::PLEN_W'(j) < eff_len;
      fixed  = pb != lpf_pkg::WILDCARD;
      if (in_len && fixed && (line_cnt_i == lpf_pkg::LINE_CNT_W'(j)) &&
          (pb != data_byte_i)) begin
        match_o.byte_miss = 1'b1;
      end
      if (in_len && fixed && (line_cnt_i <= lpf_pkg::LINE_CNT_W'(j)) &&
          (pb != '0)) begin
        match_o.tail_miss = 1'b1;
      end
    end
  end

endmodule

[rtl/line_prefix_filter.sv]
// Top level of the line prefix filter: input register, search state, result register.
// Depends on lpf_pkg, the channel interfaces in lpf_if and the lpf_match compare unit.
//
//   channel  dir  transfer when           payload
//   in_i     in   in_i.valid & ready      opcode, data_byte
//   out_o    out  out_o.valid & ready     search_status, message_index
//   cfg_i    in   cfg_i.valid & ready     index, data (always ready)
//
// One item is taken every cycle unless out_o stalls; its result, if any, is registered.
// The sustained rate is set by the single input register feeding the single result register.
// Reset clears the search state, both valid bits and the configuration to its reset values.
// While a result waits on out_o, the item in the input register holds and in_i.ready drops
// only once that register is full.
module line_prefix_filter #(
  parameter int unsigned PREFIX_BYTES      = 8,
  parameter int unsigned MESSAGE_LIMIT_MAX = 65535
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpf_in_if.sink    in_i,
  lpf_out_if.source out_o,
  lpf_cfg_if.sink   cfg_i
);

  localparam int unsigned PFX_W = PREFIX_BYTES * lpf_pkg::DATA_W;
  localparam int unsigned MD_W  = $clog2(MESSAGE_LIMIT_MAX + 1);

  logic [PFX_W-1:0]               prefix_q;
  logic [lpf_pkg::PLEN_W-1:0]     prefix_len_q;
  logic [lpf_pkg::MAXLEN_W-1:0]   max_len_q;
  logic [lpf_pkg::LIMIT_W-1:0]    limit_q;

  logic                           s1_valid_q, s1_valid_d;
  logic [lpf_pkg::OPCODE_W-1:0]   s1_op_q;
  logic [lpf_pkg::DATA_W-1:0]     s1_byte_q;

  lpf_pkg::phase_e                phase_q, phase_d;
  logic [lpf_pkg::LINE_CNT_W-1:0] line_cnt_q, line_cnt_d;
  logic                           mismatch_q, mismatch_d;
  logic [MD_W-1:0]                msgs_q, msgs_d;

  logic                           out_valid_q, out_valid_d;
  logic [lpf_pkg::STATUS_W-1:0]   out_status_q, out_status_d;
  logic [lpf_pkg::INDEX_W-1:0]    out_index_q, out_index_d;

  logic                           out_free, proc;
  lpf_pkg::op_e                   op;
  logic [lpf_pkg::LIMIT_W-1:0]    eff_limit;
  logic [MD_W-1:0]                msgs_inc;
  logic                           limit_hit, overlong, line_miss;
  lpf_pkg::match_t                match;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q     <= '0;
      prefix_len_q <= '0;
      max_len_q    <= lpf_pkg::MAXLEN_RESET;
      limit_q      <= lpf_pkg::LIMIT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        lpf_pkg::CFG_PREFIX_CHARS:    prefix_q     <= cfg_i.data[PFX_W-1:0];
        lpf_pkg::CFG_PREFIX_LENGTH:   prefix_len_q <= cfg_i.data[lpf_pkg::PLEN_W-1:0];
        lpf_pkg::CFG_MAX_LINE_LENGTH: max_len_q    <= cfg_i.data[lpf_pkg::MAXLEN_W-1:0];
        lpf_pkg::CFG_MESSAGE_LIMIT:   limit_q      <= cfg_i.data[lpf_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign proc       = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign s1_valid_d = in_i.ready ? in_i.valid : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_op_q   <= in_i.opcode;
      s1_byte_q <= in_i.data_byte;
    end
  end

  lpf_match #(
    .PREFIX_BYTES(PREFIX_BYTES)
  ) u_match (
    .prefix_i    (prefix_q),
    .prefix_len_i(prefix_len_q),
    .line_cnt_i  (line_cnt_q),
    .data_byte_i (s1_byte_q),
    .match_o     (match)
  );

  assign op        = lpf_pkg::op_e'(s1_op_q);
  assign eff_limit = (limit_q > lpf_pkg::LIMIT_W'(MESSAGE_LIMIT_MAX)) ?
                     lpf_pkg::LIMIT_W'(MESSAGE_LIMIT_MAX) : limit_q;
  assign msgs_inc  = msgs_q + 1'b1;
  assign limit_hit = lpf_pkg::LIMIT_W'(msgs_inc) >= eff_limit;
  assign overlong  = line_cnt_q > lpf_pkg::LINE_CNT_W'(max_len_q);
  assign line_miss = mismatch_q || match.tail_miss;

  always_comb begin
    phase_d = phase_q;
    if (proc) begin
      unique case (op)
        lpf_pkg::OP_START: begin
          phase_d = (eff_limit == '0) ? lpf_pkg::PH_IDLE : lpf_pkg::PH_START;
        end
        lpf_pkg::OP_TIMEOUT: phase_d = lpf_pkg::PH_IDLE;
        lpf_pkg::OP_BYTE: begin
          priority if (phase_q == lpf_pkg::PH_IDLE) begin
            phase_d = lpf_pkg::PH_IDLE;
          end else if (phase_q == lpf_pkg::PH_AFTER_CR ||
                       (!overlong && s1_byte_q == lpf_pkg::CH_LF)) begin
            phase_d = (!line_miss || limit_hit) ? lpf_pkg::PH_IDLE : lpf_pkg::PH_START;
          end else if (overlong) begin
            phase_d = lpf_pkg::PH_IDLE;
          end else if (s1_byte_q == lpf_pkg::CH_CR) begin
            phase_d = lpf_pkg::PH_AFTER_CR;
          end else begin
            phase_d = lpf_pkg::PH_LINE;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    line_cnt_d   = line_cnt_q;
    mismatch_d   = mismatch_q;
    msgs_d       = msgs_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    if (proc) begin
      unique case (op)
        lpf_pkg::OP_START: begin
          line_cnt_d = '0;
          mismatch_d = 1'b0;
          msgs_d     = '0;
          if (eff_limit == '0) begin
            out_valid_d  = 1'b1;
            out_status_d = lpf_pkg::ST_LIMIT;
            out_index_d  = '0;
          end
        end
        lpf_pkg::OP_TIMEOUT: begin
          if (phase_q != lpf_pkg::PH_IDLE) begin
            out_valid_d  = 1'b1;
            out_status_d = (phase_q == lpf_pkg::PH_START) ? lpf_pkg::ST_NO_DATA :
                                                            lpf_pkg::ST_LINE_ERR;
            out_index_d  = lpf_pkg::INDEX_W'(msgs_q);
          end
        end
        lpf_pkg::OP_BYTE: begin
          priority if (phase_q == lpf_pkg::PH_IDLE) begin
            out_valid_d = out_valid_q && !out_o.ready;
          end else if (phase_q == lpf_pkg::PH_AFTER_CR ||
                       (!overlong && s1_byte_q == lpf_pkg::CH_LF)) begin
            if (!line_miss) begin
              out_valid_d  = 1'b1;
              out_status_d = lpf_pkg::ST_FOUND;
              out_index_d  = lpf_pkg::INDEX_W'(msgs_q);
            end else begin
              msgs_d     = msgs_inc;
              line_cnt_d = '0;
              mismatch_d = 1'b0;
              if (limit_hit) begin
                out_valid_d  = 1'b1;
                out_status_d = lpf_pkg::ST_LIMIT;
                out_index_d  = lpf_pkg::INDEX_W'(msgs_inc);
              end
            end
          end else if (overlong) begin
            out_valid_d  = 1'b1;
            out_status_d = lpf_pkg::ST_LINE_ERR;
            out_index_d  = lpf_pkg::INDEX_W'(msgs_q);
          end else if (s1_byte_q != lpf_pkg::CH_CR) begin
            mismatch_d = mismatch_q || match.byte_miss;
            line_cnt_d = line_cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lpf_pkg::PH_IDLE;
      line_cnt_q  <= '0;
      mismatch_q  <= 1'b0;
      msgs_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      line_cnt_q  <= line_cnt_d;
      mismatch_q  <= mismatch_d;
      msgs_q      <= msgs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.search_status = out_status_q;
  assign out_o.message_index = out_index_q;

endmodule
